// ===== rtl/core/fifo_tlb_macros.svh =====
// Assertion macros shared by the translation buffer modules.
`ifndef FIFO_TLB_MACROS_SVH
`define FIFO_TLB_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTLB_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTLB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/ftlb_pkg.sv =====
`default_nettype none

package ftlb_pkg;

    localparam int TAG_BITS     = 20;
    localparam int FRAME_BITS   = 20;
    localparam int ENTRIES_DEF  = 16;
    localparam int ACT_W        = 5;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        REG_ACTIVE = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_RESULT = 2'd2
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [TAG_BITS-1:0]   page_tag;
        logic [FRAME_BITS-1:0] frame_in;
    } req_item_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
    } rsp_item_t;

    typedef struct packed {
        logic load_in;
        logic execute;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftlb_ctrl.sv =====
`default_nettype none
`include "fifo_tlb_macros.svh"

module ftlb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ftlb_pkg::cmd_t     cmd
);
    import ftlb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.load_in = req_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = !out_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;

    `FTLB_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_reg == ST_EXEC,
        "Accepted item did not enter execution.")
    `FTLB_ASSERT_NEXT(a_exec_result, state_reg == ST_EXEC, state_reg == ST_RESULT,
        "Execution did not move on to the result.")
    `FTLB_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_reg || !rsp_stall,
        "Result loaded over a pending item.")

endmodule

`default_nettype wire

// ===== rtl/core/ftlb_dpath.sv =====
`default_nettype none
`include "fifo_tlb_macros.svh"

module ftlb_dpath #(
    parameter int ENTRIES = ftlb_pkg::ENTRIES_DEF,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ftlb_pkg::cmd_t       cmd,
    input  wire ftlb_pkg::req_item_t  req,
    input  wire logic [CNT_W-1:0]     live,
    input  wire logic                 cfg_clear,
    output ftlb_pkg::rsp_item_t       rsp
);
    import ftlb_pkg::*;

    localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    req_item_t             item_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [TAG_BITS-1:0]   tag_reg [ENTRIES];
    logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_rd_reg;
    rsp_item_t             rsp_reg;

    logic [ENTRIES-1:0]    match;
    logic [PTR_W-1:0]      match_idx;
    logic [CNT_W-1:0]      slot;
    logic [CNT_W-1:0]      slot_inc;
    logic [PTR_W-1:0]      wr_addr;
    logic                  enabled;
    logic                  do_insert;

    assign enabled   = live != '0;
    assign do_insert = cmd.execute && enabled && item_reg.op == OP_INSERT;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && tag_reg[i] == item_reg.page_tag;
        end
    end

    always_comb
    begin
        match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                match_idx = PTR_W'(i);
            end
        end
    end

    always_comb
    begin
        slot = CNT_W'(ptr_reg);
        if (slot >= live)
        begin
            slot = '0;
        end
        slot_inc = slot + CNT_W'(1);
        if (slot_inc >= live)
        begin
            slot_inc = '0;
        end
        wr_addr = PTR_W'(slot);
    end

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (cfg_clear)
        begin
            valid_next = '0;
            ptr_next   = '0;
        end
        else if (cmd.execute && enabled)
        begin
            case (item_reg.op)
                OP_INSERT:
                begin
                    valid_next[wr_addr] = 1'b1;
                    ptr_next            = PTR_W'(slot_inc);
                end
                OP_INVAL:
                begin
                    valid_next = valid_reg & ~match;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg <= req;
        end
        if (do_insert)
        begin
            tag_reg[wr_addr] <= item_reg.page_tag;
        end
        if (cmd.execute)
        begin
            hit_reg <= item_reg.op == OP_LOOKUP && (|match);
        end
        if (cmd.load_out)
        begin
            rsp_reg.hit       <= hit_reg;
            rsp_reg.frame_out <= hit_reg ? frame_rd_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            frame_mem[wr_addr] <= item_reg.frame_in;
        end
        if (cmd.execute)
        begin
            frame_rd_reg <= frame_mem[match_idx];
        end
    end

    assign rsp = rsp_reg;

    `FTLB_ASSERT_NOW(a_ptr_range, 1'b1, live == '0 || CNT_W'(ptr_reg) < live,
        "Replacement pointer beyond the active entries.")
    `FTLB_ASSERT_NEXT(a_cfg_clears, cfg_clear, valid_reg == '0 && ptr_reg == '0,
        "Configuration write did not clear the entries.")

endmodule

`default_nettype wire

// ===== rtl/core/fifo_tlb.sv =====
// Fully associative translation buffer with round-robin replacement.
// An accepted item is compared and its frame is read in the execute state; the result
// is loaded in the result state. Items are accepted only in the idle state.
// The result register lets the next item be accepted while a result waits.
// Reset: all entries invalid, replacement pointer zero, active_entries 16.
`default_nettype none

module fifo_tlb #(
    parameter int ENTRIES = ftlb_pkg::ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire ftlb_pkg::req_item_t           req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output ftlb_pkg::rsp_item_t                rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ftlb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ftlb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ftlb_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import ftlb_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    logic [ACT_W-1:0] active_reg;
    logic [ACT_W-1:0] active_next;
    logic             cfg_clear;
    logic [CMP_W-1:0] act_ext;
    logic [CNT_W-1:0] live;
    reg_idx_t         reg_sel;
    cmd_t             cmd;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign cfg_clear = psel && penable && pwrite && pready && reg_sel == REG_ACTIVE;

    always_comb
    begin
        active_next = active_reg;
        if (cfg_clear)
        begin
            active_next = pwdata[ACT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ACTIVE:
            begin
                prdata = PDATA_W'(active_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign act_ext = CMP_W'(active_reg);
    assign live    = (act_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(act_ext);

    ftlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    ftlb_dpath #(
        .ENTRIES (ENTRIES),
        .CNT_W   (CNT_W)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .live      (live),
        .cfg_clear (cfg_clear),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
